// File: hw/rtl/global_timer_comparator_unit_defines.svh
// ----------------------------------------------------------------------------
// Global timer comparator unit - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GLOBAL_TIMER_COMPARATOR_UNIT_DEFINES_SVH
`define GLOBAL_TIMER_COMPARATOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define GTC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gtc assertion failed");

// Next-cycle implication
`define GTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gtc assertion failed");

`endif

// File: hw/rtl/gtc_pkg.sv
// ----------------------------------------------------------------------------
// Global timer comparator package
// Transaction types, opcodes, register indices and control bit positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_CNT_LO  = 3'd0,
    REG_CNT_HI  = 3'd1,
    REG_CTRL    = 3'd2,
    REG_STATUS  = 3'd3,
    REG_CMP_LO  = 3'd4,
    REG_CMP_HI  = 3'd5,
    REG_AUTOINC = 3'd6
  } reg_e;

  localparam int unsigned CTRL_ENABLE      = 0;
  localparam int unsigned CTRL_COMP_ENABLE = 1;
  localparam int unsigned CTRL_IRQ_ENABLE  = 2;
  localparam int unsigned CTRL_AUTO_INC    = 3;
  localparam int unsigned CTRL_PRESC_LSB   = 8;
  localparam int unsigned PRESC_W          = 8;
  localparam int unsigned CTRL_W           = 16;
  localparam logic [CTRL_W-1:0] CTRL_WRITE_MASK = 16'hFF0F;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        event_flag;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

// File: hw/rtl/global_timer_comparator_unit.sv
// ----------------------------------------------------------------------------
// Global timer comparator unit - top level
// 64-bit prescaled counter with comparator, auto-increment and status flag,
// driven by a stream of tick, read and write transactions.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------
//   in      | input     | in_valid_i/in_stall_o | gtc_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | gtc_pkg::out_item_t
//
// One transaction per cycle sustained while the result is not stalled; each
// accepted transaction passes the input register, then the result register.
// State updates as a transaction moves into the result register; the path
// is one 64-bit increment and compare, with the comparator add alongside.
// Asynchronous active-low reset clears all timer state and both stages.
// A stalled result holds and, with both stages full, stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "global_timer_comparator_unit_defines.svh"

module global_timer_comparator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gtc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gtc_pkg::out_item_t out_item_o
);

  gtc_pkg::stage_t    stage;
  gtc_pkg::out_item_t result;
  logic               adv;
  logic               fire;

  assign fire = stage.valid && adv;

  gtc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .adv_i      (adv),
    .stage_o    (stage)
  );

  gtc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage.item),
    .result_o (result)
  );

  gtc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  `GTC_ASSERT_SAME(a_full_stalls, stage.valid && out_valid_o && out_stall_i, in_stall_o)
  `GTC_ASSERT_SAME(a_irq_needs_flag, out_valid_o && out_item_o.irq, out_item_o.event_flag)
  `GTC_ASSERT_NEXT(a_accept_fills, in_valid_i && !in_stall_o, stage.valid)
  `GTC_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_o)

endmodule

// File: hw/rtl/gtc_in_reg.sv
// ----------------------------------------------------------------------------
// Global timer comparator - input register
// Captures one transaction per cycle; stalls only when the stage is full
// and cannot advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtc_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gtc_pkg::in_item_t in_item_i,
  input  logic              adv_i,
  output gtc_pkg::stage_t   stage_o
);

  logic              valid_q;
  gtc_pkg::in_item_t item_q;

  assign in_stall_o = valid_q && !adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// File: hw/rtl/gtc_core.sv
// ----------------------------------------------------------------------------
// Global timer comparator - timer core
// Holds counter, control, comparator and status state; applies one
// transaction per fire and forms its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  gtc_pkg::in_item_t  item_i,
  output gtc_pkg::out_item_t result_o
);

  logic [63:0]                  cnt_q,   cnt_d;
  logic [63:0]                  cmp_q,   cmp_d;
  logic [31:0]                  inc_q,   inc_d;
  logic [gtc_pkg::CTRL_W-1:0]   ctrl_q,  ctrl_d;
  logic [gtc_pkg::PRESC_W-1:0]  presc_q, presc_d;
  logic                         flag_q,  flag_d;
  logic [31:0]                  rd;
  logic [gtc_pkg::PRESC_W-1:0]  presc_lim;

  assign presc_lim = ctrl_q[gtc_pkg::CTRL_PRESC_LSB +: gtc_pkg::PRESC_W];

  always_comb begin
    cnt_d   = cnt_q;
    cmp_d   = cmp_q;
    inc_d   = inc_q;
    ctrl_d  = ctrl_q;
    presc_d = presc_q;
    flag_d  = flag_q;
    rd      = 32'd0;
    case (gtc_pkg::op_e'(item_i.op))
      gtc_pkg::OP_TICK: begin
        if (ctrl_q[gtc_pkg::CTRL_ENABLE]) begin
          if (presc_q >= presc_lim) begin
            presc_d = '0;
            cnt_d   = cnt_q + 64'd1;
          end else begin
            presc_d = presc_q + 8'd1;
          end
        end
        if (ctrl_q[gtc_pkg::CTRL_COMP_ENABLE] && (cnt_d >= cmp_q)) begin
          flag_d = 1'b1;
          if (ctrl_q[gtc_pkg::CTRL_AUTO_INC]) begin
            cmp_d = cmp_q + {32'd0, inc_q};
          end
        end
      end
      gtc_pkg::OP_READ: begin
        case (gtc_pkg::reg_e'(item_i.reg_index))
          gtc_pkg::REG_CNT_LO:  rd = cnt_q[31:0];
          gtc_pkg::REG_CNT_HI:  rd = cnt_q[63:32];
          gtc_pkg::REG_CTRL:    rd = {16'd0, ctrl_q & gtc_pkg::CTRL_WRITE_MASK};
          gtc_pkg::REG_STATUS:  rd = {31'd0, flag_q};
          gtc_pkg::REG_CMP_LO:  rd = cmp_q[31:0];
          gtc_pkg::REG_CMP_HI:  rd = cmp_q[63:32];
          gtc_pkg::REG_AUTOINC: rd = inc_q;
          default:              rd = 32'd0;
        endcase
      end
      gtc_pkg::OP_WRITE: begin
        case (gtc_pkg::reg_e'(item_i.reg_index))
          gtc_pkg::REG_CNT_LO: begin
            if (!ctrl_q[gtc_pkg::CTRL_ENABLE]) cnt_d[31:0] = item_i.write_data;
          end
          gtc_pkg::REG_CNT_HI: begin
            if (!ctrl_q[gtc_pkg::CTRL_ENABLE]) cnt_d[63:32] = item_i.write_data;
          end
          gtc_pkg::REG_CTRL: begin
            ctrl_d = item_i.write_data[gtc_pkg::CTRL_W-1:0] & gtc_pkg::CTRL_WRITE_MASK;
          end
          gtc_pkg::REG_STATUS: begin
            if (item_i.write_data[0]) flag_d = 1'b0;
          end
          gtc_pkg::REG_CMP_LO:  cmp_d[31:0]  = item_i.write_data;
          gtc_pkg::REG_CMP_HI:  cmp_d[63:32] = item_i.write_data;
          gtc_pkg::REG_AUTOINC: inc_d        = item_i.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      cmp_q   <= '0;
      inc_q   <= '0;
      ctrl_q  <= '0;
      presc_q <= '0;
      flag_q  <= 1'b0;
    end else if (fire_i) begin
      cnt_q   <= cnt_d;
      cmp_q   <= cmp_d;
      inc_q   <= inc_d;
      ctrl_q  <= ctrl_d;
      presc_q <= presc_d;
      flag_q  <= flag_d;
    end
  end

  assign result_o.read_data  = rd;
  assign result_o.irq        = flag_d & ctrl_d[gtc_pkg::CTRL_IRQ_ENABLE];
  assign result_o.event_flag = flag_d;

endmodule

// File: hw/rtl/gtc_out_reg.sv
// ----------------------------------------------------------------------------
// Global timer comparator - result register
// Holds one result transaction; advances when empty or being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtc_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  gtc_pkg::out_item_t result_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gtc_pkg::out_item_t out_item_o
);

  logic               valid_q;
  gtc_pkg::out_item_t item_q;

  assign adv_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
